// ----- hw/rtl/size_class_slab_allocator_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SCSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/scsa_pkg.sv -----
package scsa_pkg;

	localparam int unsigned PageBytes   = 65536;
	localparam int unsigned PoolPages   = 64;
	localparam int unsigned ClassCount  = 7;
	localparam int unsigned MaxBlocks   = 1024;
	localparam int unsigned PageHdr     = 16;
	localparam int unsigned BlockHdr    = 8;

	localparam int unsigned AddrW   = 22;
	localparam int unsigned PageOffW = $clog2(PageBytes);
	localparam int unsigned PageW   = $clog2(PoolPages);
	localparam int unsigned ClaimW  = $clog2(PoolPages + 1);
	localparam int unsigned ClsW    = 3;
	localparam int unsigned RemW    = $clog2(MaxBlocks + 1);
	localparam int unsigned LinkDepth = PoolPages * (PageBytes / 64);
	localparam int unsigned LinkW   = $clog2(LinkDepth);

	typedef logic [AddrW-1:0] addr_t;
	typedef logic [ClsW-1:0]  cls_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_NO_PAGES  = 3'd2,
		ST_NULL      = 3'd3,
		ST_NOT_SLAB  = 3'd4
	} status_t;

	localparam logic [3:0] TagNone = 4'd15;

	// Blocks that fit in one page per class, capped at the per-page maximum.
	localparam int unsigned PageRoom = PageBytes - PageHdr;
	localparam int unsigned Fit0 = PageRoom / ((64 << 0) + BlockHdr);
	localparam int unsigned Fit1 = PageRoom / ((64 << 1) + BlockHdr);
	localparam int unsigned Fit2 = PageRoom / ((64 << 2) + BlockHdr);
	localparam int unsigned Fit3 = PageRoom / ((64 << 3) + BlockHdr);
	localparam int unsigned Fit4 = PageRoom / ((64 << 4) + BlockHdr);
	localparam int unsigned Fit5 = PageRoom / ((64 << 5) + BlockHdr);
	localparam int unsigned Fit6 = PageRoom / ((64 << 6) + BlockHdr);
	localparam int unsigned Bpp0 = (Fit0 > MaxBlocks) ? MaxBlocks : Fit0;
	localparam int unsigned Bpp1 = (Fit1 > MaxBlocks) ? MaxBlocks : Fit1;
	localparam int unsigned Bpp2 = (Fit2 > MaxBlocks) ? MaxBlocks : Fit2;
	localparam int unsigned Bpp3 = (Fit3 > MaxBlocks) ? MaxBlocks : Fit3;
	localparam int unsigned Bpp4 = (Fit4 > MaxBlocks) ? MaxBlocks : Fit4;
	localparam int unsigned Bpp5 = (Fit5 > MaxBlocks) ? MaxBlocks : Fit5;
	localparam int unsigned Bpp6 = (Fit6 > MaxBlocks) ? MaxBlocks : Fit6;

	// Block stride per class (payload plus header), as a constant table.
	function automatic logic [PageOffW:0] stride(input cls_t c);
		logic [PageOffW:0] s;
		s = '0;
		for (int i = 0; i < ClassCount; i++) begin
			if (c == cls_t'(i)) s = (PageOffW+1)'((64 << i) + BlockHdr);
		end
		return s;
	endfunction

	function automatic logic [RemW-1:0] bpp_sel(input cls_t c);
		logic [RemW-1:0] n;
		case (c)
			3'd0: n = RemW'(Bpp0);
			3'd1: n = RemW'(Bpp1);
			3'd2: n = RemW'(Bpp2);
			3'd3: n = RemW'(Bpp3);
			3'd4: n = RemW'(Bpp4);
			3'd5: n = RemW'(Bpp5);
			3'd6: n = RemW'(Bpp6);
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

// ----- hw/rtl/scsa_link_ram.sv -----
module scsa_link_ram (
	input  logic                 clk,
	input  logic                 we,
	input  logic [scsa_pkg::LinkW-1:0] waddr,
	input  scsa_pkg::addr_t      wdata,
	input  logic [scsa_pkg::LinkW-1:0] raddr,
	output scsa_pkg::addr_t      rdata
);
	import scsa_pkg::*;

	addr_t mem [LinkDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/size_class_slab_allocator.sv -----
// Size-class slab buffer manager.
// Requests arrive on the in channel (in_valid/in_ready) with mode, req_size and
// block_addr; one result per request leaves on the out channel
// (out_valid/out_ready) with result_addr, size_class and status.
// An allocate chooses the smallest of seven classes (64 to 4096 bytes) that fits
// and pops that class's free list, or carves a fresh block from the class's
// current page, claiming a new pool page when that page is used up.
// A free looks up the page's class tag and pushes the block on that class's list.
// Each request runs as a short sequence: the step after the transfer decodes the
// class and issues the reads of the link memory and the page tag memory; the
// next step has the registered read data, updates the state and loads the
// result register. One more step returns the sequencer to idle, and the next
// request is taken only there, so a new request is not accepted while one is
// in the sequence; it may be taken while the last result still waits.
// Reset clears the list heads, the claim count and the carve counters. Neither
// memory is cleared: a page at or above the claim count reads as untagged, and
// every link entry is pushed before it is popped.
// When the receiver stalls, the result register holds its item, and the
// sequencer waits in its update step until the register is free.
module size_class_slab_allocator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [15:0]            req_size,
	input  logic [21:0]            block_addr,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [21:0]            result_addr,
	output logic [2:0]             size_class,
	output logic [2:0]             status
);
	import scsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_WAIT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Request registers.
	logic       mode_q;
	logic [15:0] size_q;
	addr_t      addr_q;

	// Allocator state small enough to live in flip-flops.
	addr_t             head_q  [ClassCount];
	logic [ClaimW-1:0] claimed_q;
	logic [PageW-1:0]  cpage_q [ClassCount];
	logic [RemW-1:0]   crem_q  [ClassCount];

	// Page class tags, one entry per pool page. Pages are claimed in order, so
	// only pages below the claim count hold a valid tag.
	logic [3:0] tag_mem [PoolPages];
	logic       tag_we;
	logic [3:0] tag_rd_q;
	logic       fpage_ok_q;
	logic [3:0] ftag;

	// Decode results captured in the read step.
	cls_t    cls_q;
	logic    fits_q;

	logic link_we;
	logic [LinkW-1:0] link_waddr, link_raddr;
	addr_t link_wdata, link_rdata;

	scsa_link_ram u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// Class choice: smallest class whose block size covers the request.
	cls_t cls_d;
	logic fits_d;
	always_comb begin
		cls_d  = '0;
		fits_d = 1'b0;
		for (int i = ClassCount - 1; i >= 0; i--) begin
			if (32'(size_q) <= (32'd64 << i)) begin
				cls_d  = cls_t'(i);
				fits_d = 1'b1;
			end
		end
	end

	// Page of a free request; unclaimed pages read as untagged.
	logic [AddrW-PageOffW-1:0] fpage;
	assign fpage = addr_q[AddrW-1:PageOffW];
	assign ftag  = fpage_ok_q ? tag_rd_q : TagNone;

	addr_t read_addr;
	assign read_addr  = mode_q ? addr_q : head_q[cls_d];
	assign link_raddr = LinkW'(read_addr[AddrW-1:6]);

	// Write-back step values.
	addr_t   res_d;
	status_t st_d;
	cls_t    ocls_d;
	logic [PageOffW+RemW:0] carve_off;
	logic [PageW-1:0] cpage_d;
	logic [RemW-1:0]  crem_d;
	logic claim_d;

	assign in_ready = (state_q == S_IDLE);

	logic out_free;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		res_d   = '0;
		st_d    = ST_OK;
		ocls_d  = '0;
		claim_d = 1'b0;
		cpage_d = cpage_q[cls_q];
		crem_d  = crem_q[cls_q];
		carve_off = '0;
		link_we = 1'b0;
		link_waddr = LinkW'(addr_q[AddrW-1:6]);
		link_wdata = '0;
		if (!mode_q) begin
			if (!fits_q) begin
				st_d = ST_TOO_LARGE;
			end else begin
				ocls_d = cls_q;
				if (head_q[cls_q] != '0) begin
					res_d = head_q[cls_q];
				end else begin
					if (crem_q[cls_q] == '0) begin
						if (bpp_sel(cls_q) == '0 || 32'(claimed_q) >= PoolPages) begin
							st_d = ST_NO_PAGES;
						end else begin
							claim_d = 1'b1;
							cpage_d = PageW'(claimed_q);
							crem_d  = bpp_sel(cls_q);
						end
					end
					if (st_d == ST_OK) begin
						crem_d = crem_d - 1'b1;
						carve_off = (PageOffW+RemW+1)'(crem_d) * (PageOffW+RemW+1)'(stride(cls_q))
							+ (PageOffW+RemW+1)'(PageHdr + BlockHdr);
						res_d = AddrW'({cpage_d, carve_off[PageOffW-1:0]});
					end
				end
			end
		end else begin
			if (addr_q == '0) begin
				st_d = ST_NULL;
			end else if (ftag >= 4'(ClassCount)) begin
				st_d = ST_NOT_SLAB;
			end else begin
				ocls_d     = cls_t'(ftag);
				link_we    = (state_q == S_WAIT) && out_free;
				link_wdata = head_q[cls_t'(ftag)];
			end
		end
	end

	// A page is tagged when an allocate claims it.
	assign tag_we = (state_q == S_WAIT) && out_free && claim_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			claimed_q <= '0;
			for (int i = 0; i < ClassCount; i++) begin
				head_q[i]  <= '0;
				cpage_q[i] <= '0;
				crem_q[i]  <= '0;
			end
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (out_free) begin
						state_q   <= S_DONE;
						out_valid <= 1'b1;
						if (!mode_q && st_d == ST_OK) begin
							if (head_q[cls_q] != '0) begin
								head_q[cls_q] <= link_rdata;
							end else begin
								cpage_q[cls_q] <= cpage_d;
								crem_q[cls_q]  <= crem_d;
								if (claim_d) begin
									claimed_q <= claimed_q + 1'b1;
								end
							end
						end
						if (mode_q && st_d == ST_OK) begin
							head_q[cls_t'(ftag)] <= addr_q;
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[PageW'(claimed_q)] <= {1'b0, cls_q};
		end
		if (state_q == S_READ) begin
			tag_rd_q <= tag_mem[fpage[PageW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			size_q <= req_size;
			addr_q <= block_addr;
		end
		if (state_q == S_READ) begin
			cls_q      <= cls_d;
			fits_q     <= fits_d;
			fpage_ok_q <= (32'(fpage) < 32'(claimed_q));
		end
		if (state_q == S_WAIT && out_free) begin
			result_addr <= res_d;
			size_class  <= ocls_d;
			status      <= st_d;
		end
	end

endmodule

// ----- hw/rtl/scsa_checker.sv -----
`include "size_class_slab_allocator_macros.svh"

module scsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [21:0] result_addr,
	input logic [2:0]  size_class,
	input logic [2:0]  status
);
	import scsa_pkg::*;

	// A result that is not taken stays put.
	`SCSA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_addr), "stalled result changed")

	// Only successful allocates return an address.
	`SCSA_ASSERT_IMP(a_addr_ok, clk, arst_n, out_valid && result_addr != 22'd0, status == 3'(ST_OK), "address with error status")

	// Status codes stay within the defined set.
	`SCSA_ASSERT_IMP(a_status_range, clk, arst_n, out_valid, status <= 3'(ST_NOT_SLAB), "status out of range")

	// No new request is taken in the cycle after one was accepted.
	`SCSA_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "request taken while busy")

	// Errors other than out-of-pages report class zero.
	`SCSA_ASSERT_IMP(a_err_class, clk, arst_n, out_valid && (status == 3'(ST_TOO_LARGE) || status == 3'(ST_NULL) || status == 3'(ST_NOT_SLAB)), size_class == 3'd0, "error result with nonzero class")

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_addr (result_addr),
	.size_class  (size_class),
	.status      (status)
);

// ----- verif/tb_size_class_slab_allocator.sv -----
// Testbench for the size-class slab buffer manager.
// Requests are driven on the in channel and results are collected on the out
// channel. A scoreboard class keeps its own copy of the allocator state (list
// heads, page tags, carve counters and the link store), predicts the result of
// every request at its transfer, and compares each result transfer with the
// oldest prediction, field by field.
module tb_size_class_slab_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import scsa_pkg::*;

	localparam int unsigned SlabClasses = 7;
	localparam int unsigned SlabPages   = 64;
	localparam int unsigned LinkEntries = SlabPages * 1024;
	localparam int unsigned RandomCount = 450;
	localparam int unsigned StallLimit  = 20000;
	localparam int unsigned RequestAlloc = 0;
	localparam int unsigned RequestFree  = 1;

	typedef struct packed {
		logic [21:0] addr;
		logic [2:0]  cls;
		status_t     st;
	} slab_result_t;

	// Scoreboard that mirrors the allocator and checks its results.
	class slab_scoreboard;
		logic [21:0]  list_head[SlabClasses];
		logic [3:0]   page_tag[SlabPages];
		int unsigned  claimed;
		int unsigned  carve_pg[SlabClasses];
		int unsigned  carve_left[SlabClasses];
		logic [21:0]  link_mem[LinkEntries];
		slab_result_t pending[$];
		int unsigned  mismatches;
		int unsigned  results_seen;
		int unsigned  status_hits[5];
		// Payload addresses handed out and not yet freed, for well-formed frees.
		logic [21:0]  live[$];

		function new();
			for (int c = 0; c < SlabClasses; c++) begin
				list_head[c] = '0;
				carve_pg[c] = 0;
				carve_left[c] = 0;
			end
			for (int p = 0; p < SlabPages; p++) page_tag[p] = TagNone;
			claimed = 0;
			mismatches = 0;
			results_seen = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function int unsigned blocks_for(int unsigned c);
			int unsigned n;
			n = (65536 - 16) / ((64 << c) + 8);
			return (n > 1024) ? 1024 : n;
		endfunction

		// Notes one accepted request and queues the result it must produce.
		function void note_request(logic m, logic [15:0] sz, logic [21:0] ba);
			slab_result_t r;
			int unsigned c;
			int unsigned pg;
			bit found;
			r = '{addr: '0, cls: '0, st: ST_OK};
			found = 0;
			if (m == RequestAlloc[0]) begin
				for (int i = 0; i < SlabClasses; i++) begin
					if (!found && sz <= (64 << i)) begin
						found = 1;
						c = i;
					end
				end
				if (!found) begin
					r.st = ST_TOO_LARGE;
				end else begin
					r.cls = 3'(c);
					if (list_head[c] != 0) begin
						r.addr = list_head[c];
						list_head[c] = link_mem[r.addr >> 6];
					end else begin
						if (carve_left[c] == 0) begin
							if (claimed >= SlabPages) begin
								r.st = ST_NO_PAGES;
							end else begin
								carve_pg[c] = claimed;
								page_tag[claimed] = 4'(c);
								claimed++;
								carve_left[c] = blocks_for(c);
							end
						end
						if (r.st == ST_OK) begin
							carve_left[c]--;
							r.addr = 22'(carve_pg[c] * 65536 + 16
								+ carve_left[c] * ((64 << c) + 8) + 8);
						end
					end
					if (r.st == ST_OK) live.push_back(r.addr);
				end
			end else begin
				if (ba == 0) begin
					r.st = ST_NULL;
				end else begin
					pg = ba >> 16;
					if (pg >= SlabPages || page_tag[pg] >= SlabClasses) begin
						r.st = ST_NOT_SLAB;
					end else begin
						link_mem[ba >> 6] = list_head[page_tag[pg]];
						list_head[page_tag[pg]] = ba;
						r.cls = page_tag[pg][2:0];
					end
				end
			end
			pending.push_back(r);
		endfunction

		// Compares one result transfer with the oldest prediction.
		function void check_result(logic [21:0] a, logic [2:0] c, logic [2:0] s);
			slab_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: addr=%h class=%0d status=%0d", a, c, s);
				return;
			end
			e = pending.pop_front();
			if (e.st <= ST_NOT_SLAB) status_hits[e.st]++;
			if (a !== e.addr || c !== e.cls || s !== e.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected addr=%h class=%0d status=%0d, %s",
						e.addr, e.cls, e.st,
						$sformatf("got addr=%h class=%0d status=%0d", a, c, s));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [15:0] req_size;
	logic [21:0] block_addr;
	logic        out_valid;
	logic        out_ready;
	logic [21:0] result_addr;
	logic [2:0]  size_class;
	logic [2:0]  status;

	slab_scoreboard board;
	bit          quiet_phase;
	int unsigned idle_cycles;
	int unsigned requests_sent;

	size_class_slab_allocator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.req_size   (req_size),
		.block_addr (block_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_addr(result_addr),
		.size_class (size_class),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sends one request and holds it until the transfer. The prediction is made
	// at the accepting edge, so the scoreboard sees requests in order.
	task automatic send_request(logic m, logic [15:0] sz, logic [21:0] ba);
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		req_size <= sz;
		block_addr <= ba;
		do @(posedge clk); while (!in_ready);
		board.note_request(m, sz, ba);
		requests_sent++;
	endtask

	// Picks a free target: mostly live blocks, sometimes odd or foreign addresses.
	function automatic logic [21:0] pick_free_addr();
		int unsigned k;
		logic [21:0] a;
		k = $urandom_range(0, 9);
		if (k < 7 && board.live.size() > 0) begin
			k = $urandom_range(0, board.live.size() - 1);
			a = board.live[k];
			board.live.delete(k);
			return a;
		end
		if (k == 7) return 22'($urandom);
		if (k == 8) return '0;
		// Misaligned address inside a tagged page, accepted unchecked.
		if (board.claimed > 0)
			return 22'(($urandom_range(0, board.claimed - 1) << 16) | $urandom_range(1, 65535));
		return 22'($urandom);
	endfunction

	// Receiver side: random stall bursts, then always ready in the last part.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Results are checked at the edge of their transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(result_addr, size_class, status);
	end

	// Watchdog: counts cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("Timeout: no transfer for %0d cycles", StallLimit);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned k;
		board = new();
		quiet_phase = 0;
		requests_sent = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		req_size = '0;
		block_addr = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: size zero, several class edges, oversize, null and non-slab
		// frees, frees of two carved blocks and their reuse by pops.
		send_request(RequestAlloc[0], 16'd0, '0);
		send_request(RequestAlloc[0], 16'd64, '0);
		send_request(RequestAlloc[0], 16'd65, '0);
		send_request(RequestAlloc[0], 16'd256, '0);
		send_request(RequestAlloc[0], 16'd512, '0);
		send_request(RequestAlloc[0], 16'd1024, '0);
		send_request(RequestAlloc[0], 16'd2048, '0);
		send_request(RequestAlloc[0], 16'd4096, '0);
		send_request(RequestAlloc[0], 16'd4097, '0);
		send_request(RequestAlloc[0], 16'hFFFF, '0);
		send_request(RequestFree[0], 16'hFFFF, '0);
		send_request(RequestFree[0], '0, 22'h3FFFFF);
		send_request(RequestFree[0], '0, 22'h3F0000);
		send_request(RequestFree[0], '0, board.live[0]);
		send_request(RequestFree[0], '0, board.live[1]);
		send_request(RequestAlloc[0], 16'd1, '0);
		send_request(RequestAlloc[0], 16'd40, '0);
		send_request(RequestAlloc[0], 16'd33, '0);
		board.live.delete(0);
		board.live.delete(0);

		// Random part: mostly allocations and frees of live blocks, with noise.
		// The largest class takes a page per 15 blocks, so many pages get claimed.
		for (int i = 0; i < RandomCount; i++) begin
			if (i > RandomCount - 60) quiet_phase = 1;
			k = $urandom_range(0, 99);
			if (k < 50)
				send_request(RequestAlloc[0], 16'($urandom_range(0, 4096)),
					22'($urandom));
			else if (k < 58)
				send_request(RequestAlloc[0], 16'($urandom), 22'($urandom));
			else
				send_request(RequestFree[0], 16'($urandom), pick_free_addr());
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests, checked %0d results; %0d pages claimed.",
			requests_sent, board.results_seen, board.claimed);
		$display("Status counts ok/too large/no pages/null/not slab: %0d/%0d/%0d/%0d/%0d",
			board.status_hits[0], board.status_hits[1], board.status_hits[2],
			board.status_hits[3], board.status_hits[4]);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("Mismatches: %0d", board.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
